// ===== rtl/ba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ba_pkg
// Shared types, constants and helpers of the buddy allocator core.
// ----------------------------------------------------------------------------
package ba_pkg;

   localparam int MAX_ORDER = 10;
   localparam int MAP_W     = MAX_ORDER + 1;        // free map index bits
   localparam int ROW_LG    = 5;
   localparam int ROW_W     = 2 ** ROW_LG;          // bits per map row
   localparam int ROW_AW    = MAP_W - ROW_LG;       // row address bits
   localparam int ROWS      = 2 ** ROW_AW;
   localparam int ADDR_W    = MAX_ORDER;
   localparam int SIZE_W    = MAX_ORDER + 1;
   localparam int ORD_W     = 4;

   typedef logic [MAP_W-1:0]  idx_type;
   typedef logic [ROW_AW-1:0] row_type;
   typedef logic [ROW_W-1:0]  word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [ORD_W-1:0]  ord_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_RANGE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SPLIT,
      S_RMW_RD,
      S_RMW_WR,
      S_BUD,
      S_BUD_RD,
      S_BUD_CHK,
      S_RESP
   } state_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // first map index of order k
   function automatic idx_type order_base(input ord_type k);
      idx_type one;
      one = idx_type'(1);
      return one << (ord_type'(MAX_ORDER) - k);
   endfunction

   // smallest n with 2^n >= size
   function automatic ord_type ceil_log2(input size_type size);
      ord_type n;
      size_type p;
      n = ord_type'(MAX_ORDER);
      for (int i = MAX_ORDER; i >= 0; i--) begin
         p = size_type'(1) << i;
         if (p >= size) begin
            n = ord_type'(i);
         end
      end
      return n;
   endfunction

   // lowest set bit of a row
   function automatic logic [ROW_LG-1:0] low_bit(input word_type w);
      logic [ROW_LG-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            r = ROW_LG'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/buddy_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_allocator_core
// Binary buddy allocator; per-order free bitmaps held in a row-wide RAM.
// ----------------------------------------------------------------------------
// per request, each scanned row takes S_SCAN_RD and S_SCAN_CHK, each order S_RANGE,
//   split steps S_SPLIT, S_RMW_RD, S_RMW_WR; merge steps S_BUD, S_BUD_RD, S_BUD_CHK
// throughput: one request at a time; the next is taken once a result is registered
// reset and each pool_order write run a bitmap clearing pass over all 64 rows,
//   during which no request is taken
module buddy_allocator_core
   import ba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // request_size, free_start, end_address, pad
   input  wire logic        req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // status, address, block_order
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata
);

   state_type  state_ff, state_in;
   ord_type    pool_ff, pool_in;
   row_type    clr_ff, clr_in;
   logic       act_ff, act_in;
   size_type   size_ff, size_in;
   addr_type   start_ff, start_in;
   addr_type   end_ff, end_in;
   ord_type    n_ff, n_in;
   ord_type    k_ff, k_in;
   addr_type   addr_ff, addr_in;
   idx_type    lo_ff, lo_in;
   idx_type    hi_ff, hi_in;
   row_type    row_ff, row_in;
   idx_type    ptr_ff, ptr_in;
   logic       setbit_ff, setbit_in;
   status_type stat_ff, stat_in;
   addr_type   raddr_ff, raddr_in;
   ord_type    rord_ff, rord_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic     wr_en;
   row_type  wr_addr;
   word_type wr_data;
   row_type  rd_addr;
   word_type rd_data;

   ba_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   idx_type  root_idx;
   word_type mask;
   word_type hits;
   idx_type  hit_idx;
   idx_type  cur_idx;
   size_type fsize;
   size_type pool_size;
   size_type fsum;
   idx_type  rel;

   assign root_idx  = order_base(pool_ff);
   assign pool_size = size_type'(1) << pool_ff;
   assign fsize     = size_type'(end_ff) - size_type'(start_ff) + size_type'(1);
   assign fsum      = size_type'(start_ff) + fsize;

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         cur_idx = {row_ff, ROW_LG'(i)};
         mask[i] = (cur_idx >= lo_ff) && (cur_idx <= hi_ff);
      end
      cur_idx = {row_ff, ROW_LG'(0)};
   end

   assign hits    = rd_data & mask;
   assign hit_idx = {row_ff, low_bit(hits)};
   assign rel     = hit_idx - order_base(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pool_ff      <= ord_type'(MAX_ORDER);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      size_ff     <= size_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      addr_ff     <= addr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      row_ff      <= row_in;
      ptr_ff      <= ptr_in;
      setbit_ff   <= setbit_in;
      stat_ff     <= stat_in;
      raddr_ff    <= raddr_in;
      rord_ff     <= rord_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      clr_in       = clr_ff;
      act_in       = act_ff;
      size_in      = size_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      setbit_in    = setbit_ff;
      stat_in      = stat_ff;
      raddr_in     = raddr_ff;
      rord_in      = rord_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[MAP_W-1:ROW_LG];
      wr_data      = rd_data;
      rd_addr      = row_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == root_idx[MAP_W-1:ROW_LG]) begin
               wr_data[root_idx[ROW_LG-1:0]] = 1'b1;
            end
            clr_in = clr_ff + row_type'(1);
            if (clr_ff == row_type'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in   = req_tuser;
               size_in  = req_tdata[10:0];
               start_in = req_tdata[20:11];
               end_in   = req_tdata[30:21];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            stat_in  = ST_INVALID;
            raddr_in = '0;
            rord_in  = '0;
            if (act_ff == ACT_ALLOC) begin
               if (size_ff == '0 || size_ff > pool_size) begin
                  state_in = S_RESP;
               end else begin
                  n_in     = ceil_log2(size_ff);
                  k_in     = ceil_log2(size_ff);
                  state_in = S_RANGE;
               end
            end else begin
               if (end_ff < start_ff || (fsize & (fsize - size_type'(1))) != '0 ||
                   (size_type'(start_ff) & (fsize - size_type'(1))) != '0 ||
                   fsum > pool_size) begin
                  state_in = S_RESP;
               end else begin
                  n_in     = ceil_log2(fsize);
                  k_in     = '0;
                  state_in = S_RANGE;
               end
            end
         end
         S_RANGE: begin
            if (act_ff == ACT_ALLOC) begin
               lo_in = order_base(k_ff);
               hi_in = order_base(k_ff) + (idx_type'(1) << (pool_ff - k_ff)) - idx_type'(1);
               row_in = row_type'(order_base(k_ff) >> ROW_LG);
            end else begin
               lo_in = order_base(k_ff) + idx_type'(start_ff >> k_ff);
               hi_in = order_base(k_ff) + idx_type'(end_ff >> k_ff);
               row_in = row_type'((order_base(k_ff) + idx_type'(start_ff >> k_ff)) >> ROW_LG);
            end
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            rd_addr  = row_ff;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (hits != '0) begin
               if (act_ff == ACT_ALLOC) begin
                  addr_in   = addr_type'(rel << k_ff);
                  ptr_in    = hit_idx;
                  setbit_in = 1'b0;
                  state_in  = S_RMW_RD;
               end else begin
                  stat_in  = ST_INVALID;
                  raddr_in = '0;
                  rord_in  = '0;
                  state_in = S_RESP;
               end
            end else if (row_ff == hi_ff[MAP_W-1:ROW_LG]) begin
               if (k_ff >= pool_ff) begin
                  if (act_ff == ACT_ALLOC) begin
                     stat_in  = ST_NOMEM;
                     raddr_in = '0;
                     rord_in  = '0;
                     state_in = S_RESP;
                  end else begin
                     k_in     = n_ff;
                     addr_in  = start_ff;
                     state_in = S_BUD;
                  end
               end else begin
                  k_in     = k_ff + ord_type'(1);
                  state_in = S_RANGE;
               end
            end else begin
               row_in   = row_ff + row_type'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            if (k_ff > n_ff) begin
               ptr_in    = order_base(k_ff - ord_type'(1)) +
                           idx_type'(addr_ff >> (k_ff - ord_type'(1))) + idx_type'(1);
               setbit_in = 1'b1;
               k_in      = k_ff - ord_type'(1);
               state_in  = S_RMW_RD;
            end else begin
               stat_in  = ST_OK;
               raddr_in = addr_ff;
               rord_in  = n_ff;
               state_in = S_RESP;
            end
         end
         S_RMW_RD: begin
            rd_addr  = ptr_ff[MAP_W-1:ROW_LG];
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            wr_data[ptr_ff[ROW_LG-1:0]] = setbit_ff;
            if (act_ff == ACT_ALLOC) begin
               state_in = S_SPLIT;
            end else begin
               stat_in  = ST_OK;
               raddr_in = start_ff;
               rord_in  = n_ff;
               state_in = S_RESP;
            end
         end
         S_BUD: begin
            if (k_ff < pool_ff) begin
               ptr_in   = order_base(k_ff) + idx_type'((addr_ff >> k_ff) ^ addr_type'(1));
               state_in = S_BUD_RD;
            end else begin
               ptr_in    = order_base(k_ff) + idx_type'(addr_ff >> k_ff);
               setbit_in = 1'b1;
               state_in  = S_RMW_RD;
            end
         end
         S_BUD_RD: begin
            rd_addr  = ptr_ff[MAP_W-1:ROW_LG];
            state_in = S_BUD_CHK;
         end
         S_BUD_CHK: begin
            if (rd_data[ptr_ff[ROW_LG-1:0]]) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               wr_data[ptr_ff[ROW_LG-1:0]] = 1'b0;
               addr_in  = addr_ff & ~(addr_type'(1) << k_ff);
               k_in     = k_ff + ord_type'(1);
               state_in = S_BUD;
            end else begin
               ptr_in    = order_base(k_ff) + idx_type'(addr_ff >> k_ff);
               setbit_in = 1'b1;
               state_in  = S_RMW_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rord_ff, raddr_ff, stat_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      if (csr_we) begin
         pool_in  = (csr_wdata > 4'(MAX_ORDER)) ? ord_type'(MAX_ORDER) : ord_type'(csr_wdata);
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/ba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
